### design/tsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants for the tone sequencer queue
// Word field widths, action codes, queue entry and control structs, and the
// note-number to frequency table.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int NOTE_W = 6;
    localparam int FREQ_W = 12;
    localparam int LEN_W  = 16;

    // Action codes carried by the input word
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // One queued note
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [LEN_W-1:0]  len;
    } tsq_entry_t;

    // Queue requests from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } tsq_ctrl_t;

    // Queue status back to the sequencer
    typedef struct packed {
        logic full;
        logic empty;
    } tsq_status_t;

    // Note number to frequency in Hz; note 0 and numbers past the table are rests
    function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        case (idx)
            6'd0:  f = 12'd0;
            6'd1:  f = 12'd139;
            6'd2:  f = 12'd148;
            6'd3:  f = 12'd156;
            6'd4:  f = 12'd165;
            6'd5:  f = 12'd175;
            6'd6:  f = 12'd185;
            6'd7:  f = 12'd196;
            6'd8:  f = 12'd207;
            6'd9:  f = 12'd220;
            6'd10: f = 12'd233;
            6'd11: f = 12'd247;
            6'd12: f = 12'd262;
            6'd13: f = 12'd277;
            6'd14: f = 12'd294;
            6'd15: f = 12'd311;
            6'd16: f = 12'd330;
            6'd17: f = 12'd349;
            6'd18: f = 12'd370;
            6'd19: f = 12'd392;
            6'd20: f = 12'd415;
            6'd21: f = 12'd440;
            6'd22: f = 12'd466;
            6'd23: f = 12'd494;
            6'd24: f = 12'd523;
            6'd25: f = 12'd554;
            6'd26: f = 12'd587;
            6'd27: f = 12'd622;
            6'd28: f = 12'd659;
            6'd29: f = 12'd698;
            6'd30: f = 12'd740;
            6'd31: f = 12'd784;
            6'd32: f = 12'd830;
            6'd33: f = 12'd880;
            6'd34: f = 12'd932;
            6'd35: f = 12'd988;
            6'd36: f = 12'd1046;
            6'd37: f = 12'd1109;
            6'd38: f = 12'd1174;
            6'd39: f = 12'd1244;
            6'd40: f = 12'd1318;
            6'd41: f = 12'd1397;
            6'd42: f = 12'd1480;
            6'd43: f = 12'd1568;
            6'd44: f = 12'd1661;
            6'd45: f = 12'd1720;
            6'd46: f = 12'd1865;
            6'd47: f = 12'd1975;
            6'd48: f = 12'd2093;
            6'd49: f = 12'd2217;
            6'd50: f = 12'd2349;
            6'd51: f = 12'd2489;
            6'd52: f = 12'd2637;
            6'd53: f = 12'd2794;
            6'd54: f = 12'd2960;
            6'd55: f = 12'd3136;
            6'd56: f = 12'd3332;
            6'd57: f = 12'd3440;
            6'd58: f = 12'd3729;
            6'd59: f = 12'd3951;
            default: f = 12'd0;
        endcase
        return f;
    endfunction

endpackage

### design/tsq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_ram: simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tsq_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### design/tsq_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_fifo: show-ahead note queue
// RAM-backed FIFO with a front register so the oldest entry is always
// presented combinationally; a pop can follow a pop or push every cycle.
// ----------------------------------------------------------------------------
module tsq_fifo
    import tsq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tsq_ctrl_t   ctrl,
    input  wire tsq_entry_t  wr_entry,
    output tsq_entry_t       head,
    output tsq_status_t      status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(tsq_entry_t);

    // entry counts: total, and those still held in RAM
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ram_cnt_reg, ram_cnt_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;

    // front entry, and a RAM read whose data lands this cycle
    logic       front_valid_reg, front_valid_next;
    tsq_entry_t front_reg, front_next;
    logic       fetch_reg, fetch_next;

    logic       head_valid;
    logic       head_keep;
    logic       fetch_issue;
    logic       push_ram;
    logic       push_front;
    tsq_entry_t ram_rdata;

    tsq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_ram),
        .waddr (wr_ptr_reg),
        .wdata (wr_entry),
        .re    (fetch_issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // head is either the front register or the word arriving from RAM
    assign head_valid = front_valid_reg | fetch_reg;
    assign head       = fetch_reg ? ram_rdata : front_reg;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    // refill and push steering
    always_comb
    begin
        head_keep   = head_valid & ~ctrl.pop;
        fetch_issue = ~head_keep & (ram_cnt_reg != '0);
        push_ram    = ctrl.push & head_valid;
        push_front  = ctrl.push & ~head_valid;
    end

    // next state
    always_comb
    begin
        count_next       = count_reg;
        ram_cnt_next     = ram_cnt_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        front_valid_next = head_keep;
        front_next       = front_reg;
        fetch_next       = fetch_issue;

        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end

        // arriving RAM word settles in the front register unless consumed
        if (fetch_reg & ~ctrl.pop)
        begin
            front_next = ram_rdata;
        end

        if (push_front)
        begin
            front_valid_next = 1'b1;
            front_next       = wr_entry;
        end

        if (push_ram)
        begin
            ram_cnt_next = ram_cnt_reg + 1'b1;
            wr_ptr_next  = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        else if (fetch_issue)
        begin
            ram_cnt_next = ram_cnt_reg - 1'b1;
        end

        if (fetch_issue)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            ram_cnt_reg     <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            front_valid_reg <= 1'b0;
            fetch_reg       <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            ram_cnt_reg     <= ram_cnt_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            front_valid_reg <= front_valid_next;
            fetch_reg       <= fetch_next;
        end
    end

    // front payload
    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

`ifndef ASSERT_OFF
    // front register and RAM word in flight never both hold the head
    a_single_head: assert property (@(posedge clk) disable iff (!rst_n)
        !(front_valid_reg && fetch_reg))
        else $error("tsq_fifo: front and fetch both valid");

    // a head word is presented exactly when the queue is not empty
    a_head_present: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid == (count_reg != '0))
        else $error("tsq_fifo: head presence disagrees with count");

    // total count equals RAM entries plus the head entry
    a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == ram_cnt_reg + CW'(head_valid))
        else $error("tsq_fifo: count split mismatch");

    // no pop on empty, no push on full
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (count_reg != '0))
        else $error("tsq_fifo: pop while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> (count_reg <= CW'(DEPTH)))
        else $error("tsq_fifo: count beyond depth");
`endif

endmodule
`default_nettype wire

### design/tone_sequencer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// A word accepted into the input register moves to the result register unless stalled.
// Throughput: one word per cycle while out_stall is low; the queue head sits in a front
// register fed by the note RAM, so back-to-back ticks and enqueues never wait on the RAM read.
// Reset (rst_n, async, active low) empties the queue, clears the note timer and
// the playing flag; queue RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// tone_sequencer_queue: buzzer note queue sequencer
// Enqueues notes as frequency and length, and on each tick counts down the
// current note and pops the next one, emitting the tone to drive.
// ----------------------------------------------------------------------------
module tone_sequencer_queue
    import tsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              action,
    input  wire logic [NOTE_W-1:0] note_index,
    input  wire logic [LEN_W-1:0]  note_length,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   tone_write,
    output logic [FREQ_W-1:0]      tone_freq,
    output logic                   note_dropped,
    output logic                   playing
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic              action_reg;
    logic [NOTE_W-1:0] note_index_reg;
    logic [LEN_W-1:0]  note_length_reg;

    // sequencer state
    logic [LEN_W-1:0]  timer_reg, timer_next;
    logic              playing_reg, playing_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              tone_write_reg, tone_write_next;
    logic [FREQ_W-1:0] tone_freq_reg, tone_freq_next;
    logic              dropped_reg, dropped_next;
    logic              out_playing_reg;

    logic              advance;
    logic              in_accept;
    logic              fire;
    logic              enq;
    logic              tick;
    logic [LEN_W-1:0]  timer_dec;
    logic              tick_hit;

    tsq_ctrl_t         q_ctrl;
    tsq_entry_t        q_wr;
    tsq_entry_t        q_head;
    tsq_status_t       q_status;

    tsq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (q_ctrl),
        .wr_entry (q_wr),
        .head     (q_head),
        .status   (q_status)
    );

    // handshake
    assign advance   = ~out_valid_reg | ~out_stall;
    assign in_stall  = in_valid_reg & ~advance;
    assign in_accept = in_valid & ~in_stall;
    assign fire      = in_valid_reg & advance;

    // decode and queue requests
    always_comb
    begin
        enq       = fire & (action_reg == ACT_ENQUEUE);
        tick      = fire & (action_reg == ACT_TICK);
        timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
        tick_hit  = playing_reg & (timer_dec == '0);

        q_ctrl.push = enq & ~q_status.full;
        q_ctrl.pop  = tick & tick_hit & ~q_status.empty;
        q_wr.freq   = note_freq(note_index_reg);
        q_wr.len    = note_length_reg;
    end

    // timer and playing flag
    always_comb
    begin
        timer_next   = timer_reg;
        playing_next = playing_reg;
        if (enq)
        begin
            playing_next = 1'b1;
        end
        else if (tick)
        begin
            timer_next = timer_dec;
            if (tick_hit)
            begin
                if (q_status.empty)
                begin
                    playing_next = 1'b0;
                end
                else
                begin
                    timer_next = q_head.len;
                end
            end
        end
    end

    // result word
    always_comb
    begin
        tone_write_next = tick & tick_hit;
        tone_freq_next  = q_ctrl.pop ? q_head.freq : '0;
        dropped_next    = enq & q_status.full;
        out_valid_next  = advance ? in_valid_reg : out_valid_reg;
        in_valid_next   = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timer_reg     <= '0;
            playing_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            timer_reg     <= timer_next;
            playing_reg   <= playing_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg      <= action;
            note_index_reg  <= note_index;
            note_length_reg <= note_length;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tone_write_reg  <= tone_write_next;
            tone_freq_reg   <= tone_freq_next;
            dropped_reg     <= dropped_next;
            out_playing_reg <= playing_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tone_write   = tone_write_reg;
    assign tone_freq    = tone_freq_reg;
    assign note_dropped = dropped_reg;
    assign playing      = out_playing_reg;

`ifndef ASSERT_OFF
    // a waiting result is never overwritten while stalled
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !fire)
        else $error("tone_sequencer_queue: result overwritten under stall");

    // a tone write with a non-zero tone only comes with a queue pop
    a_tone_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && tone_freq_next != '0) |-> q_ctrl.pop)
        else $error("tone_sequencer_queue: tone without pop");

    // an enqueue always leaves the block playing
    a_enq_plays: assert property (@(posedge clk) disable iff (!rst_n)
        enq |=> playing_reg)
        else $error("tone_sequencer_queue: enqueue did not set playing");
`endif

endmodule
`default_nettype wire

### tb/tb_tone_sequencer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_sequencer_queue: self-checking bench for the tone sequencer queue
// Drives enqueue and tick words with random gaps and output stalls. Every
// accepted word is run through a local model of the note queue, the note
// timer and the playing flag, and each result word is checked against it.
// ----------------------------------------------------------------------------
module tb_tone_sequencer_queue;

    import tsq_pkg::*;

    localparam int NOTE_SLOTS  = 128;
    localparam int ROM_NOTES   = 60;
    localparam int CYCLE_LIMIT = 60000;

    // One input word as queued for the driver
    typedef struct packed {
        logic              act;
        logic [NOTE_W-1:0] idx;
        logic [LEN_W-1:0]  len;
        logic              hold;  // wait for an empty result queue before sending
    } note_word_t;

    // One queued note in the local model
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [LEN_W-1:0]  len;
    } queued_note_t;

    // One expected result word
    typedef struct packed {
        logic              tone_wr;
        logic [FREQ_W-1:0] freq;
        logic              dropped;
        logic              play;
    } tone_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              action = ACT_ENQUEUE;
    logic [NOTE_W-1:0] note_index = '0;
    logic [LEN_W-1:0]  note_length = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              tone_write;
    logic [FREQ_W-1:0] tone_freq;
    logic              note_dropped;
    logic              playing;

    // Frequency per note number, rest at 0
    logic [FREQ_W-1:0] hz_table [ROM_NOTES] = '{
        12'd0,    12'd139,  12'd148,  12'd156,  12'd165,  12'd175,
        12'd185,  12'd196,  12'd207,  12'd220,  12'd233,  12'd247,
        12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
        12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
        12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
        12'd740,  12'd784,  12'd830,  12'd880,  12'd932,  12'd988,
        12'd1046, 12'd1109, 12'd1174, 12'd1244, 12'd1318, 12'd1397,
        12'd1480, 12'd1568, 12'd1661, 12'd1720, 12'd1865, 12'd1975,
        12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
        12'd2960, 12'd3136, 12'd3332, 12'd3440, 12'd3729, 12'd3951
    };

    note_word_t   note_words[$];
    tone_result_t due_tones[$];
    queued_note_t note_fifo[$];
    logic [LEN_W-1:0] note_timer = '0;
    logic             play_flag = 1'b0;

    int  total_words = 0;
    int  words_taken = 0;
    int  words_sent = 0;
    int  mismatches = 0;
    int  cycles = 0;
    logic in_fire = 1'b0;
    logic calm;

    tone_sequencer_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .note_index   (note_index),
        .note_length  (note_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tone_write   (tone_write),
        .tone_freq    (tone_freq),
        .note_dropped (note_dropped),
        .playing      (playing)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Model one accepted word and queue the result it should give
    task automatic sequence_step(input logic act, input logic [NOTE_W-1:0] idx,
                                 input logic [LEN_W-1:0] len);
        tone_result_t r;
        queued_note_t n;
        r = '0;
        if (act == ACT_ENQUEUE)
        begin
            if (note_fifo.size() >= NOTE_SLOTS)
                r.dropped = 1'b1;
            else
            begin
                n.freq = (int'(idx) < ROM_NOTES) ? hz_table[int'(idx)] : '0;
                n.len  = len;
                note_fifo.push_back(n);
            end
            play_flag = 1'b1;
        end
        else
        begin
            if (note_timer != 0)
                note_timer = note_timer - 1'b1;
            if (play_flag && note_timer == 0)
            begin
                r.tone_wr = 1'b1;
                if (note_fifo.size() != 0)
                begin
                    n = note_fifo.pop_front();
                    note_timer = n.len;
                    r.freq = n.freq;
                end
                else
                    play_flag = 1'b0;
            end
        end
        r.play = play_flag;
        due_tones.push_back(r);
    endtask

    task automatic add_word(input logic act, input int idx, input int len, input logic hold);
        note_word_t w;
        w.act  = act;
        w.idx  = idx[NOTE_W-1:0];
        w.len  = len[LEN_W-1:0];
        w.hold = hold;
        note_words.push_back(w);
    endtask

    // Short length most of the time, now and then a longer one
    function automatic int pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(0, 2);
        else if (p < 95)
            return $urandom_range(0, 7);
        return $urandom_range(0, 31);
    endfunction

    task automatic add_mixed(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                add_word(ACT_ENQUEUE, $urandom_range(0, 63), pick_len(), 1'b0);
            else
                add_word(ACT_TICK, $urandom_range(0, 63), $urandom_range(0, 65535), 1'b0);
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        // idle tick, then notes covering rest, top note, numbers past the table
        add_word(ACT_TICK, 0, 0, 1'b0);
        add_word(ACT_ENQUEUE, 0, 0, 1'b0);
        add_word(ACT_ENQUEUE, 59, 1, 1'b0);
        add_word(ACT_ENQUEUE, 63, 2, 1'b0);
        add_word(ACT_ENQUEUE, 60, 0, 1'b0);
        add_word(ACT_ENQUEUE, 1, 3, 1'b0);
        for (int i = 0; i < 10; i++)
            add_word(ACT_TICK, 63, 16'hFFFF, 1'b0);
        // enqueue while a note is running, then zero length, then stop
        add_word(ACT_ENQUEUE, 33, 2, 1'b0);
        add_word(ACT_TICK, 0, 0, 1'b0);
        add_word(ACT_ENQUEUE, 21, 0, 1'b0);
        for (int i = 0; i < 4; i++)
            add_word(ACT_TICK, 0, 0, 1'b0);

        // random mix, first word held back until the pipe is drained
        add_word(ACT_TICK, 5, 5, 1'b1);
        add_mixed(100);

        // overfill the queue; the last word carries the longest length and is dropped
        for (int i = 0; i < 134; i++)
            add_word(ACT_ENQUEUE, $urandom_range(0, 63), $urandom_range(0, 1), i == 0);
        add_word(ACT_ENQUEUE, 42, 16'hFFFF, 1'b0);
        for (int i = 0; i < 200; i++)
            add_word(ACT_TICK, $urandom_range(0, 63), $urandom_range(0, 65535), 1'b0);

        add_mixed(100);

        // long note at the very end so it never holds up the rest
        add_word(ACT_ENQUEUE, 45, 16'hFFFF, 1'b0);
        for (int i = 0; i < 3; i++)
            add_word(ACT_TICK, 0, 0, 1'b0);
        total_words = note_words.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken < total_words || due_tones.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb_tone_sequencer_queue: clean");
        else
            $display("tb_tone_sequencer_queue: errors");
        $finish;
    end

    // No idling or output stalls from partway through the queue overfill until just after it
    assign calm = (words_sent >= 140) && (words_sent < 280);

    // Driver: present the next word at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (note_words.size() != 0
                    && !(note_words[0].hold && due_tones.size() != 0)
                    && (calm || $urandom_range(0, 99) >= 23))
                begin
                    action      <= note_words[0].act;
                    note_index  <= note_words[0].idx;
                    note_length <= note_words[0].len;
                    in_valid    <= 1'b1;
                    void'(note_words.pop_front());
                    words_sent  <= words_sent + 1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 23);
        end
    end

    // Monitor: model accepted words, then check result words
    always @(posedge clk)
    begin
        tone_result_t e;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sequence_step(action, note_index, note_length);
                words_taken <= words_taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (due_tones.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    e = due_tones.pop_front();
                    if (tone_write !== e.tone_wr)
                    begin
                        $error("tone_write: expected %0d, got %0d", e.tone_wr, tone_write);
                        mismatches++;
                    end
                    if (tone_freq !== e.freq)
                    begin
                        $error("tone_freq: expected %0d, got %0d", e.freq, tone_freq);
                        mismatches++;
                    end
                    if (note_dropped !== e.dropped)
                    begin
                        $error("note_dropped: expected %0d, got %0d", e.dropped, note_dropped);
                        mismatches++;
                    end
                    if (playing !== e.play)
                    begin
                        $error("playing: expected %0d, got %0d", e.play, playing);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_tone_sequencer_queue: errors");
            $finish;
        end
    end

endmodule

### filelist.f
design/tsq_pkg.sv
design/tsq_ram.sv
design/tsq_fifo.sv
design/tone_sequencer_queue.sv
tb/tb_tone_sequencer_queue.sv
